// File: src/esmv_pkg.sv
// Shared types and constants for the ELLPACK sparse matrix-vector multiplier.
`timescale 1ns / 1ps
`default_nettype none

package esmv_pkg;

  localparam int VECTOR_DEPTH = 1024;
  localparam int MAX_ROWS     = 65536;
  localparam int QUEUE_DEPTH  = 4;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int ROW_W   = 16;
  localparam int ACC_W   = 64;

  localparam logic OP_VEC_WRITE = 1'b0;
  localparam logic OP_MATRIX    = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic                      row_last;
    logic signed [VALUE_W-1:0] prior_sum;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row_number;
    logic signed [VALUE_W-1:0] row_sum;
    logic                      saturated;
  } out_t;

  // Matrix entry with its vector element, passed from front to back.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] elem;
    logic                      row_last;
    logic signed [VALUE_W-1:0] prior_sum;
  } entry_t;

endpackage

`default_nettype wire

// File: src/esmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module esmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/esmv_front.sv
// Front end: accepts transactions, writes the vector store, fetches elements.
`timescale 1ns / 1ps
`default_nettype none

module esmv_front #(
  parameter int VECTOR_DEPTH = esmv_pkg::VECTOR_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             entry_valid,
  output logic                  entry_ready,
  input  wire esmv_pkg::in_t    entry,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output esmv_pkg::entry_t      push_data
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic                                s1_valid;
  logic                                s1_in_range;
  logic signed [esmv_pkg::VALUE_W-1:0] s1_value;
  logic                                s1_row_last;
  logic signed [esmv_pkg::VALUE_W-1:0] s1_prior;
  logic [esmv_pkg::VALUE_W-1:0]        rdata;
  logic                                accept;
  logic                                in_range;
  logic                                is_matrix;
  logic [AW-1:0]                       addr;

  assign entry_ready = !s1_valid || push_ready;
  assign accept      = entry_valid && entry_ready;
  assign is_matrix   = entry.op == esmv_pkg::OP_MATRIX;
  assign in_range    = 17'(entry.index) < 17'(VECTOR_DEPTH);
  assign addr        = AW'(entry.index);

  esmv_ram #(
    .WIDTH (esmv_pkg::VALUE_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (accept && !is_matrix && in_range),
    .waddr (addr),
    .wdata (entry.value),
    .re    (accept && is_matrix),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && is_matrix) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
    if (accept && is_matrix) begin
      s1_in_range <= in_range;
      s1_value    <= entry.value;
      s1_row_last <= entry.row_last;
      s1_prior    <= entry.prior_sum;
    end
  end

  assign push_valid          = s1_valid;
  assign push_data.value     = s1_value;
  assign push_data.elem      = s1_in_range ? $signed(rdata) : '0;
  assign push_data.row_last  = s1_row_last;
  assign push_data.prior_sum = s1_prior;

endmodule

`default_nettype wire

// File: src/esmv_queue.sv
// Short queue of matrix entries between front end and back end.
`timescale 1ns / 1ps
`default_nettype none

module esmv_queue #(
  parameter int DEPTH = esmv_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire esmv_pkg::entry_t push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output esmv_pkg::entry_t      pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  esmv_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/esmv_back.sv
// Back end: multiply, row accumulate, row-end add, saturate, result register.
`timescale 1ns / 1ps
`default_nettype none

module esmv_back #(
  parameter int MAX_ROWS = esmv_pkg::MAX_ROWS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire esmv_pkg::entry_t pop_data,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output esmv_pkg::out_t        result
);

  localparam int RCW = $clog2(MAX_ROWS);
  localparam int AW  = esmv_pkg::ACC_W;

  // multiply stage
  logic                                m_valid;
  logic signed [AW-1:0]                m_prod;
  logic                                m_last;
  logic signed [esmv_pkg::VALUE_W-1:0] m_prior;
  // accumulator
  logic signed [AW-1:0]                acc;
  logic signed [AW-1:0]                acc_sum;
  logic [RCW-1:0]                      row_counter;
  // finish stage
  logic                                f_valid;
  logic signed [AW-1:0]                f_acc;
  logic signed [esmv_pkg::VALUE_W-1:0] f_prior;
  logic [esmv_pkg::ROW_W-1:0]          f_row;
  // handshakes
  logic out_free;
  logic f_free;
  logic m_move;
  logic m_free;
  // row-end arithmetic
  logic signed [AW:0]                  wide_total;
  logic signed [AW-1:0]                total;
  logic                                clip;
  esmv_pkg::out_t                      result_next;

  assign out_free  = !result_valid || result_ready;
  assign f_free    = !f_valid || out_free;
  assign m_move    = m_valid && (!m_last || f_free);
  assign m_free    = !m_valid || m_move;
  assign pop_ready = m_free;
  assign acc_sum   = acc + m_prod;

  assign wide_total = {f_acc[AW-1], f_acc}
                      + (AW+1)'($signed({f_prior, 16'b0}));

  always_comb begin
    if (wide_total[AW] != wide_total[AW-1]) begin
      total = wide_total[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      total = wide_total[AW-1:0];
    end
    clip = !((&total[AW-1:47]) || !(|total[AW-1:47]));
    result_next.row_number = f_row;
    result_next.saturated  = clip;
    if (clip) begin
      result_next.row_sum = total[AW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      result_next.row_sum = total[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid      <= 1'b0;
      f_valid      <= 1'b0;
      result_valid <= 1'b0;
      acc          <= '0;
      row_counter  <= '0;
    end else begin
      if (m_free) begin
        m_valid <= pop_valid;
      end
      if (m_move) begin
        acc <= m_last ? '0 : acc_sum;
        if (m_last) begin
          row_counter <= (row_counter == RCW'(MAX_ROWS - 1)) ? '0 : row_counter + 1'b1;
        end
      end
      if (f_free) begin
        f_valid <= m_move && m_last;
      end
      if (out_free) begin
        result_valid <= f_valid;
      end
    end
    if (m_free && pop_valid) begin
      m_prod  <= $signed(pop_data.value) * $signed(pop_data.elem);
      m_last  <= pop_data.row_last;
      m_prior <= pop_data.prior_sum;
    end
    if (m_move && m_last) begin
      f_acc   <= acc_sum;
      f_prior <= m_prior;
      f_row   <= esmv_pkg::ROW_W'(row_counter);
    end
    if (out_free && f_valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: src/ell_sparse_matvec_top.sv
// Top level of the ELLPACK sparse matrix times dense vector block.
//
//   channel  direction  handshake                    payload
//   entry    in         entry_valid / entry_ready    esmv_pkg::in_t
//   result   out        result_valid / result_ready  esmv_pkg::out_t
//
// One transaction per cycle sustained while results are taken; the multiplier and
// accumulator take one matrix entry every cycle unless stalled, the vector RAM one
// write or one read per cycle. For a row's last entry, the element read happens at
// the edge that accepts it, then queue, multiply, accumulate, and row-end add and
// saturate into the result register, where result_valid rises.
// Synchronous reset clears pipeline valids, the row accumulator and row counter;
// the vector store is not cleared. A stalled result stops the back end only; the
// queue lets the front end keep taking transactions until it fills.
`timescale 1ns / 1ps
`default_nettype none

module ell_sparse_matvec_top #(
  parameter int VECTOR_DEPTH = esmv_pkg::VECTOR_DEPTH,
  parameter int MAX_ROWS     = esmv_pkg::MAX_ROWS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           entry_valid,
  output logic                entry_ready,
  input  wire esmv_pkg::in_t  entry,
  output logic                result_valid,
  input  wire logic           result_ready,
  output esmv_pkg::out_t      result
);

  logic             push_valid;
  logic             push_ready;
  esmv_pkg::entry_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  esmv_pkg::entry_t pop_data;

  esmv_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (entry_valid),
    .entry_ready (entry_ready),
    .entry       (entry),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  esmv_queue #(
    .DEPTH (esmv_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  esmv_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: bench/ell_sparse_matvec_top_test.sv
// Self-checking testbench for the ELLPACK sparse matrix-vector block.
`timescale 1ns / 1ps

class row_sum_scoreboard;
  logic signed [esmv_pkg::VALUE_W-1:0] vec_mem [esmv_pkg::VECTOR_DEPTH];
  logic [esmv_pkg::ACC_W-1:0] acc;
  int unsigned row_count;
  esmv_pkg::out_t pending_rows[$];
  int rows_checked;
  int sat_rows;
  int wraps;
  int mismatches;

  function new();
    acc = '0;
    row_count = 0;
    rows_checked = 0;
    sat_rows = 0;
    wraps = 0;
    mismatches = 0;
  endfunction

  // Accepted input transaction: update vector and accumulator, queue any row sum.
  function void take_entry(esmv_pkg::in_t t);
    longint prod;
    longint add;
    longint total;
    longint q;
    longint hi;
    longint lo;
    logic [esmv_pkg::ACC_W:0] wide;
    esmv_pkg::out_t row;
    if (t.op == esmv_pkg::OP_VEC_WRITE) begin
      vec_mem[t.index] = t.value;
      return;
    end
    prod = longint'($signed(t.value)) * longint'(vec_mem[t.index]);
    acc = acc + prod;
    if (!t.row_last) return;
    add = longint'($signed(t.prior_sum)) * 65536;
    wide = {acc[esmv_pkg::ACC_W-1], acc} + {add[esmv_pkg::ACC_W-1], add};
    if (wide[esmv_pkg::ACC_W] != wide[esmv_pkg::ACC_W-1]) begin
      total = wide[esmv_pkg::ACC_W] ? {1'b1, {(esmv_pkg::ACC_W-1){1'b0}}}
                                    : {1'b0, {(esmv_pkg::ACC_W-1){1'b1}}};
    end else begin
      total = wide[esmv_pkg::ACC_W-1:0];
    end
    q = total >>> 16;
    hi = 64'sh7FFF_FFFF;
    lo = -hi - 1;
    row.saturated = 1'b0;
    if (q > hi) begin
      q = hi;
      row.saturated = 1'b1;
    end else if (q < lo) begin
      q = lo;
      row.saturated = 1'b1;
    end
    row.row_number = row_count[esmv_pkg::ROW_W-1:0];
    row.row_sum = q[esmv_pkg::VALUE_W-1:0];
    pending_rows.push_back(row);
    acc = '0;
    if (row_count + 1 >= esmv_pkg::MAX_ROWS) begin
      row_count = 0;
      wraps++;
    end else begin
      row_count++;
    end
  endfunction

  function void check_row(esmv_pkg::out_t got);
    esmv_pkg::out_t want;
    if (pending_rows.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected row sum: row %0d sum %h sat %0b",
                 got.row_number, got.row_sum, got.saturated);
      return;
    end
    want = pending_rows.pop_front();
    rows_checked++;
    if (want.saturated) sat_rows++;
    if (got.row_number !== want.row_number || got.row_sum !== want.row_sum ||
        got.saturated !== want.saturated) begin
      mismatches++;
      if (mismatches <= 10)
        $display("row sum mismatch: expected row %0d sum %h sat %0b, got row %0d sum %h sat %0b",
                 want.row_number, want.row_sum, want.saturated,
                 got.row_number, got.row_sum, got.saturated);
    end
  endfunction
endclass

module ell_sparse_matvec_top_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic entry_valid = 1'b0;
  logic entry_ready;
  esmv_pkg::in_t entry = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  esmv_pkg::out_t result;

  row_sum_scoreboard sb = new();

  bit vec_written [esmv_pkg::VECTOR_DEPTH];
  int unsigned written_idx[$];
  int items_sent = 0;
  int results_seen = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  ell_sparse_matvec_top dut (
    .clk(clk),
    .rst(rst),
    .entry_valid(entry_valid),
    .entry_ready(entry_ready),
    .entry(entry),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send(esmv_pkg::in_t t);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      entry_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    entry_valid <= 1'b1;
    entry <= t;
    do @(posedge clk); while (!entry_ready);
    sb.take_entry(t);
    items_sent++;
  endtask

  task automatic load_element(int unsigned idx, logic [esmv_pkg::VALUE_W-1:0] v, logic last);
    esmv_pkg::in_t t;
    t.op = esmv_pkg::OP_VEC_WRITE;
    t.index = idx[esmv_pkg::INDEX_W-1:0];
    t.value = v;
    t.row_last = last;
    t.prior_sum = $urandom;
    send(t);
    if (!vec_written[idx]) begin
      vec_written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
  endtask

  task automatic push_entry(int unsigned idx, logic [esmv_pkg::VALUE_W-1:0] v, logic last,
                            logic [esmv_pkg::VALUE_W-1:0] prior);
    esmv_pkg::in_t t;
    t.op = esmv_pkg::OP_MATRIX;
    t.index = idx[esmv_pkg::INDEX_W-1:0];
    t.value = v;
    t.row_last = last;
    t.prior_sum = prior;
    send(t);
  endtask

  function automatic int unsigned pick_column();
    return written_idx[$urandom_range(0, written_idx.size() - 1)];
  endfunction

  function automatic logic [esmv_pkg::VALUE_W-1:0] small_q();
    logic [31:0] r;
    r = $urandom;
    return {{12{r[19]}}, r[19:0]};
  endfunction

  function automatic logic [esmv_pkg::VALUE_W-1:0] rand_q();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      2, 3: return r;
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  // Result side: random back-pressure, one long hold-off to fill the block.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 3);
      if (results_seen == 40) stall = 400;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      sb.check_row(result);
      results_seen++;
      if ($urandom_range(0, 29) == 0) recv_burst = ~recv_burst;
    end
  end

  initial begin
    #40_000_000;
    $display("[ell_sparse_matvec_top] ERROR");
    $finish;
  end

  initial begin
    int width;
    int directed_items;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_element(0, 32'h7FFF_FFFF, 1'b1);
    load_element(1023, 32'h8000_0000, 1'b0);
    load_element(1, 32'h0001_0000, 1'b1);
    load_element(2, 32'hFFFF_0000, 1'b0);
    load_element(512, 32'h0000_0000, 1'b1);
    push_entry(1, 32'h0003_8000, 1'b1, 32'h0000_0000);
    // largest product plus largest prior: clips high
    push_entry(0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);
    // accumulator wraps to the minimum, prior pushes the 64-bit add past it
    push_entry(1023, 32'h8000_0000, 1'b0, 32'h0000_0000);
    push_entry(1023, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF);
    // 64-bit add overflows upward
    push_entry(0, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000);
    push_entry(0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);
    // Q16.16 range boundaries
    push_entry(1, 32'h8000_0000, 1'b1, 32'h0000_0000);
    push_entry(1, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF);
    push_entry(1, 32'h7FFF_FFFF, 1'b1, 32'h0000_0001);
    // floor on dropped fraction bits, negative and positive
    push_entry(0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
    push_entry(0, 32'h0000_0001, 1'b1, 32'h0000_0000);
    // padded row
    push_entry(512, $urandom, 1'b0, 32'h0000_0000);
    push_entry(1, 32'h0000_0000, 1'b0, 32'h0000_0000);
    push_entry(2, 32'h0002_0000, 1'b1, 32'h0001_0000);
    // read right after write
    load_element(3, 32'h0000_8000, 1'b0);
    push_entry(3, 32'h0004_0000, 1'b1, 32'h0000_0000);
    directed_items = items_sent;

    while (items_sent < directed_items + 620) begin
      if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
      if ($urandom_range(0, 4) == 0) begin
        load_element($urandom_range(0, esmv_pkg::VECTOR_DEPTH - 1), rand_q(),
                     1'($urandom_range(0, 1)));
      end else begin
        width = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        for (int k = 0; k < width; k++) begin
          if ($urandom_range(0, 15) == 0)
            load_element($urandom_range(0, esmv_pkg::VECTOR_DEPTH - 1), rand_q(),
                         1'($urandom_range(0, 1)));
          push_entry(pick_column(), rand_q(), k == width - 1,
                     $urandom_range(0, 1) ? small_q() : rand_q());
        end
      end
    end

    entry_valid <= 1'b0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d transactions sent, %0d row sums checked, %0d of them clipped",
             items_sent, sb.rows_checked, sb.sat_rows);
    $display("row counter rolled over %0d time(s), %0d vector elements in use",
             sb.wraps, written_idx.size());
    if (sb.mismatches == 0 && sb.pending_rows.size() == 0) begin
      $display("[ell_sparse_matvec_top] OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[ell_sparse_matvec_top] ERROR");
    end
    $finish;
  end

endmodule
